// File: src/sws_pkg.sv
// Package for the stop-and-wait chunk sender: widths, codes, reset values,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package sws_pkg;

    // Field widths of the channels and registers.
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int SEQ_W      = 32;
    localparam int SIZE_W     = 6;
    localparam int KIND_W     = 2;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd_code;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_PKT    = 2'd0,
        KIND_REFUSE = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_DELIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DELIM   = 2'd2;

    // Configuration reset values.
    localparam logic [TIMER_W-1:0] TIMEOUT_RST     = 16'd2000;
    localparam logic [BYTE_W-1:0]  CHUNK_DELIM_RST = 8'd44;
    localparam logic [BYTE_W-1:0]  END_DELIM_RST   = 8'd46;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_FILL = 5'b00001,
        ST_WAIT = 5'b00010,
        ST_DONE = 5'b00100,
        ST_READ = 5'b01000,
        ST_LOAD = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_byte;
        logic set_final;
        logic start_emit;
        logic retx;
        logic mem_rd;
        logic load_pkt;
        logic load_refuse;
        logic load_done;
        logic ack_advance;
        logic tick;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_end_delim;
        logic is_chunk_delim;
        logic fill_full;
        logic ack_match;
        logic final_chunk;
        logic timer_hit;
        logic last_byte;
        logic out_free;
    } t_dp_status;

endpackage

// File: src/sws_in_if.sv
// Input channel of the chunk sender: valid/ready handshake with command and data.
// Depends on sws_pkg.
interface sws_in_if;
    logic                           valid;
    logic                           ready;
    logic [sws_pkg::CMD_W-1:0]      command;
    logic [sws_pkg::BYTE_W-1:0]     source_byte;
    logic [sws_pkg::SEQ_W-1:0]      ack_seq;

    modport source (output valid, command, source_byte, ack_seq, input ready);
    modport sink   (input valid, command, source_byte, ack_seq, output ready);
endinterface

// File: src/sws_out_if.sv
// Result channel of the chunk sender: valid/ready handshake with packet fields.
// Depends on sws_pkg.
interface sws_out_if;
    logic                           valid;
    logic                           ready;
    logic [sws_pkg::KIND_W-1:0]     kind;
    logic [sws_pkg::SEQ_W-1:0]      seq;
    logic [sws_pkg::SIZE_W-1:0]     size;
    logic                           retransmit;
    logic                           payload_valid;
    logic [sws_pkg::BYTE_W-1:0]     payload;
    logic                           last;

    modport source (output valid, kind, seq, size, retransmit, payload_valid, payload, last,
                    input ready);
    modport sink   (input valid, kind, seq, size, retransmit, payload_valid, payload, last,
                    output ready);
endinterface

// File: src/sws_dp.sv
// Datapath of the chunk sender: configuration registers, chunk memory, counters,
// sequence offset, ack timer and the result register.
// Depends on sws_pkg.
module sws_dp #(
    parameter int CHUNK_MAX = 63
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sws_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sws_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [sws_pkg::BYTE_W-1:0]        i_source_byte,
    input  logic [sws_pkg::SEQ_W-1:0]         i_ack_seq,
    input  sws_pkg::t_dp_ctrl                 i_ctrl,
    output sws_pkg::t_dp_status               o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [sws_pkg::KIND_W-1:0]        o_kind,
    output logic [sws_pkg::SEQ_W-1:0]         o_seq,
    output logic [sws_pkg::SIZE_W-1:0]        o_size,
    output logic                              o_retransmit,
    output logic                              o_payload_valid,
    output logic [sws_pkg::BYTE_W-1:0]        o_payload,
    output logic                              o_last
);
    localparam int AW = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;

    // Configuration registers.
    logic [sws_pkg::TIMER_W-1:0] r_timeout;
    logic [sws_pkg::BYTE_W-1:0]  r_chunk_delim;
    logic [sws_pkg::BYTE_W-1:0]  r_end_delim;

    // Transfer state.
    logic [sws_pkg::SIZE_W-1:0]  r_fill,   n_fill;
    logic [sws_pkg::SEQ_W-1:0]   r_offset, n_offset;
    logic                        r_final;
    logic [sws_pkg::TIMER_W-1:0] r_timer,  n_timer;
    logic [sws_pkg::SIZE_W-1:0]  r_idx,    n_idx;
    logic                        r_retx;

    // Chunk memory and its registered read data.
    logic [sws_pkg::BYTE_W-1:0]  r_mem [CHUNK_MAX];
    logic [sws_pkg::BYTE_W-1:0]  r_rd_data;

    // Result register.
    logic                        r_out_valid;
    logic [sws_pkg::KIND_W-1:0]  r_kind;
    logic [sws_pkg::SEQ_W-1:0]   r_seq;
    logic [sws_pkg::SIZE_W-1:0]  r_size;
    logic                        r_rt;
    logic                        r_pv;
    logic [sws_pkg::BYTE_W-1:0]  r_pay;
    logic                        r_last;

    logic [sws_pkg::SIZE_W:0]    w_fill_inc;
    logic [sws_pkg::SEQ_W-1:0]   w_offset_adv;
    logic [sws_pkg::TIMER_W-1:0] w_timer_inc;
    logic                        w_fill_zero;
    logic                        w_last_byte;

    // Arithmetic shared by status and next-state logic.
    assign w_fill_inc   = {1'b0, r_fill} + (sws_pkg::SIZE_W+1)'(1);
    assign w_offset_adv = r_offset + sws_pkg::SEQ_W'(r_fill);
    assign w_timer_inc  = r_timer + sws_pkg::TIMER_W'(1);
    assign w_fill_zero  = (r_fill == '0);
    assign w_last_byte  = w_fill_zero || ((r_idx + sws_pkg::SIZE_W'(1)) == r_fill);

    // Status towards the controller. The end delimiter wins when both match.
    always_comb begin
        o_status.is_end_delim   = (i_source_byte == r_end_delim);
        o_status.is_chunk_delim = (i_source_byte == r_chunk_delim);
        o_status.fill_full      = (w_fill_inc >= (sws_pkg::SIZE_W+1)'(CHUNK_MAX));
        o_status.ack_match      = (i_ack_seq == r_offset);
        o_status.final_chunk    = r_final;
        o_status.timer_hit      = (w_timer_inc >= r_timeout) || (w_timer_inc == '0);
        o_status.last_byte      = w_last_byte;
        o_status.out_free       = !r_out_valid || i_out_ready;
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= sws_pkg::TIMEOUT_RST;
            r_chunk_delim <= sws_pkg::CHUNK_DELIM_RST;
            r_end_delim   <= sws_pkg::END_DELIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sws_pkg::CFG_TIMEOUT:     r_timeout     <= i_cfg_data;
                sws_pkg::CFG_CHUNK_DELIM: r_chunk_delim <= i_cfg_data[sws_pkg::BYTE_W-1:0];
                sws_pkg::CFG_END_DELIM:   r_end_delim   <= i_cfg_data[sws_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Next values of the counters and the offset.
    always_comb begin
        n_fill   = r_fill;
        n_offset = r_offset;
        n_timer  = r_timer;
        n_idx    = r_idx;
        if (i_ctrl.ack_advance) begin
            n_fill   = '0;
            n_offset = w_offset_adv;
        end else if (i_ctrl.store_byte) begin
            n_fill = w_fill_inc[sws_pkg::SIZE_W-1:0];
        end
        if (i_ctrl.start_emit || i_ctrl.ack_advance) begin
            n_timer = '0;
        end else if (i_ctrl.tick) begin
            n_timer = w_timer_inc;
        end
        if (i_ctrl.start_emit) begin
            n_idx = '0;
        end else if (i_ctrl.load_pkt) begin
            n_idx = r_idx + sws_pkg::SIZE_W'(1);
        end
    end

    // Transfer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_offset <= '0;
            r_final  <= 1'b0;
            r_timer  <= '0;
            r_idx    <= '0;
            r_retx   <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_offset <= n_offset;
            r_timer  <= n_timer;
            r_idx    <= n_idx;
            if (i_ctrl.set_final) begin
                r_final <= 1'b1;
            end
            if (i_ctrl.start_emit) begin
                r_retx <= i_ctrl.retx;
            end
        end
    end

    // Chunk memory: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.store_byte) begin
            r_mem[r_fill[AW-1:0]] <= i_source_byte;
        end
        if (i_ctrl.mem_rd) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Result valid flag: set on a load, cleared once the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load_pkt || i_ctrl.load_refuse || i_ctrl.load_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload. An empty packet carries no byte.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_pkt) begin
            r_kind <= sws_pkg::KIND_PKT;
            r_seq  <= r_offset;
            r_size <= r_fill;
            r_rt   <= r_retx;
            r_pv   <= !w_fill_zero;
            r_pay  <= w_fill_zero ? '0 : r_rd_data;
            r_last <= w_last_byte;
        end else if (i_ctrl.load_refuse || i_ctrl.load_done) begin
            r_kind <= i_ctrl.load_done ? sws_pkg::KIND_DONE : sws_pkg::KIND_REFUSE;
            r_seq  <= i_ctrl.load_done ? w_offset_adv : '0;
            r_size <= '0;
            r_rt   <= 1'b0;
            r_pv   <= 1'b0;
            r_pay  <= '0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_seq           = r_seq;
    assign o_size          = r_size;
    assign o_retransmit    = r_rt;
    assign o_payload_valid = r_pv;
    assign o_payload       = r_pay;
    assign o_last          = r_last;
endmodule

// File: src/sws_ctrl.sv
// Controller of the chunk sender: transfer phases and the packet emission sequence.
// Depends on sws_pkg.
module sws_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [sws_pkg::CMD_W-1:0]     i_command,
    input  sws_pkg::t_dp_status           i_status,
    output logic                          o_in_ready,
    output sws_pkg::t_dp_ctrl             o_ctrl
);
    sws_pkg::t_state    r_state, n_state;
    sws_pkg::t_cmd_code w_cmd;
    logic               w_accept;

    assign w_cmd = sws_pkg::t_cmd_code'(i_command);

    // Items are taken only in the phase states, with room in the result register.
    assign o_in_ready = ((r_state == sws_pkg::ST_FILL) || (r_state == sws_pkg::ST_WAIT) ||
                         (r_state == sws_pkg::ST_DONE)) && i_status.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            sws_pkg::ST_FILL: begin
                if (w_accept) begin
                    case (w_cmd)
                        sws_pkg::CMD_BYTE: begin
                            if (i_status.is_end_delim) begin
                                o_ctrl.set_final  = 1'b1;
                                o_ctrl.start_emit = 1'b1;
                            end else if (i_status.is_chunk_delim) begin
                                o_ctrl.start_emit = 1'b1;
                            end else begin
                                o_ctrl.store_byte = 1'b1;
                                o_ctrl.start_emit = i_status.fill_full;
                            end
                        end
                        sws_pkg::CMD_END: begin
                            o_ctrl.set_final  = 1'b1;
                            o_ctrl.start_emit = 1'b1;
                        end
                        default: ;
                    endcase
                    if (o_ctrl.start_emit) begin
                        n_state = sws_pkg::ST_READ;
                    end
                end
            end
            sws_pkg::ST_WAIT: begin
                if (w_accept) begin
                    case (w_cmd)
                        sws_pkg::CMD_BYTE, sws_pkg::CMD_END: begin
                            o_ctrl.load_refuse = 1'b1;
                        end
                        sws_pkg::CMD_ACK: begin
                            if (i_status.ack_match) begin
                                o_ctrl.ack_advance = 1'b1;
                                if (i_status.final_chunk) begin
                                    o_ctrl.load_done = 1'b1;
                                    n_state          = sws_pkg::ST_DONE;
                                end else begin
                                    n_state = sws_pkg::ST_FILL;
                                end
                            end else begin
                                o_ctrl.start_emit = 1'b1;
                                o_ctrl.retx       = 1'b1;
                                n_state           = sws_pkg::ST_READ;
                            end
                        end
                        sws_pkg::CMD_TICK: begin
                            o_ctrl.tick = 1'b1;
                            if (i_status.timer_hit) begin
                                o_ctrl.start_emit = 1'b1;
                                o_ctrl.retx       = 1'b1;
                                n_state           = sws_pkg::ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sws_pkg::ST_DONE: begin
                if (w_accept && (w_cmd == sws_pkg::CMD_BYTE || w_cmd == sws_pkg::CMD_END)) begin
                    o_ctrl.load_refuse = 1'b1;
                end
            end
            sws_pkg::ST_READ: begin
                o_ctrl.mem_rd = 1'b1;
                n_state       = sws_pkg::ST_LOAD;
            end
            sws_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_ctrl.load_pkt = 1'b1;
                    n_state = i_status.last_byte ? sws_pkg::ST_WAIT : sws_pkg::ST_READ;
                end
            end
            default: begin
                n_state = sws_pkg::ST_FILL;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sws_pkg::ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: src/stop_and_wait_chunk_sender_unit.sv
// Top level of the stop-and-wait chunk sender: joins controller and datapath.
// Depends on sws_pkg, sws_in_if, sws_out_if, sws_ctrl and sws_dp.
//
//   Channel   Direction  Handshake      Carries
//   i_in      in         valid/ready    command, source_byte, ack_seq
//   o_out     out        valid/ready    kind, seq, size, retransmit, payload_valid,
//                                       payload, last
//   i_cfg_*   in         write enable   register index and data, no read-back
//
// A refusal or done item is in the result register in the cycle after its input item is taken.
// A packet then passes each payload byte through a memory read and then a result load, and an
// empty packet through the same read and load; the single read port of the chunk memory sets this.
// Reset is synchronous and active low; the chunk memory needs no clearing pass.
// A stalled result register holds off both new items and packet emission.
module stop_and_wait_chunk_sender_unit #(
    parameter int CHUNK_MAX = 63
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sws_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sws_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    sws_in_if.sink                            i_in,
    sws_out_if.source                         o_out
);
    sws_pkg::t_dp_ctrl   w_ctrl;
    sws_pkg::t_dp_status w_status;
    logic                w_in_ready;

    // Controller.
    sws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_ctrl     (w_ctrl)
    );

    assign i_in.ready = w_in_ready;

    // Datapath.
    sws_dp #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_source_byte   (i_in.source_byte),
        .i_ack_seq       (i_in.ack_seq),
        .i_ctrl          (w_ctrl),
        .o_status        (w_status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_kind          (o_out.kind),
        .o_seq           (o_out.seq),
        .o_size          (o_out.size),
        .o_retransmit    (o_out.retransmit),
        .o_payload_valid (o_out.payload_valid),
        .o_payload       (o_out.payload),
        .o_last          (o_out.last)
    );

    // Input is never offered while a result is stuck in the result register.
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !(o_out.valid && !o_out.ready))
        else $error("input ready while result register is stalled");

    // A refusal only ever follows an accepted input item.
    a_refuse_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out.valid) && o_out.kind == sws_pkg::KIND_REFUSE)
            |-> $past(i_in.valid && w_in_ready))
        else $error("refusal without an accepted input item");

    // A packet item without a byte is the lone item of an empty packet.
    a_empty_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == sws_pkg::KIND_PKT && !o_out.payload_valid)
            |-> (o_out.size == '0 && o_out.last))
        else $error("empty packet item with non-zero size or not last");
endmodule
